FILE: rtl/core/rpf_pkg.sv
// Shared constants and controller/datapath handshake types for the row peak finder.
package rpf_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int INDEX_W         = 8;
    localparam int LEVEL_W         = 16;
    localparam int MAX_LEN_DEF     = 256;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_PEAKS_DEF   = 64;

    typedef struct packed {
        logic load;
        logic centre_rd;
        logic centre_cap;
        logic walk;
        logic emit_init;
        logic emit_rd;
        logic emit_cap;
        logic emit_mul;
        logic emit_add;
        logic div_step;
        logic out_load;
        logic out_none;
        logic clear_row;
    } rpf_cmd_t;

    typedef struct packed {
        logic in_last;
        logic walk_end;
        logic no_picks;
        logic div_done;
        logic emit_last;
        logic out_free;
    } rpf_sts_t;

endpackage

FILE: rtl/core/rpf_sample_if.sv
// Sample input channel: valid/ready with one row sample per beat.
interface rpf_sample_if;
    import rpf_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

FILE: rtl/core/rpf_peak_if.sv
// Peak output channel: valid/ready with one peak result per beat.
interface rpf_peak_if;
    import rpf_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] peak_index;
    logic [LEVEL_W-1:0] peak_level;
    logic               no_peak;
    logic               overflow;
    logic               last_result;

    modport source (output valid, output peak_index, output peak_level, output no_peak,
                    output overflow, output last_result, input ready);
    modport sink   (input valid, input peak_index, input peak_level, input no_peak,
                    input overflow, input last_result, output ready);
endinterface

FILE: rtl/core/row_peak_finder.sv
// Top level of the row peak finder: sequencer plus datapath.
//
// Usage: a row streams in on the samples channel, one beat per sample, with
// last_sample set on the final beat. Samples beyond MAX_LEN are dropped.
// After the final beat the block walks the stored row and then returns on
// the peaks channel one beat per qualifying peak in row order, the final
// beat carrying last_result (and overflow when peaks past MAX_PEAKS were
// dropped). A row with no peak returns a single beat with no_peak set.
// Timing: samples load at one per cycle. After the final sample come the
// centre fetch and the derivative walk, then for each peak one pick read,
// three arithmetic steps, a restoring divider that yields one level bit per
// cycle and a load of the output register.
// The single read port of the row memory sets the walk at one sample per
// cycle. samples.ready is high only while a row is loading.
// Reset clears the row length, min/max and the sequencer; the row memory
// needs no clearing. If the receiver stalls, the result beat holds in the
// output register and the sequencer waits; once the final beat sits in
// that register the next row may already load.
module row_peak_finder #(
    parameter int MAX_LEN     = rpf_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_BITS = rpf_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_PEAKS   = rpf_pkg::MAX_PEAKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rpf_sample_if.sink  samples,
    rpf_peak_if.source  peaks
);
    import rpf_pkg::*;

    rpf_cmd_t cmd;
    rpf_sts_t sts;

    rpf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    rpf_dp #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_PEAKS   (MAX_PEAKS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .peaks   (peaks),
        .cmd     (cmd),
        .sts     (sts)
    );
endmodule

FILE: rtl/core/rpf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/core/rpf_ctrl.sv
// Sequencer for row load, centre fetch, derivative walk and per-peak emission.
module rpf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  rpf_pkg::rpf_sts_t  sts,
    output rpf_pkg::rpf_cmd_t  cmd
);
    import rpf_pkg::*;

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_CREAD  = 4'd1;
    localparam logic [3:0] S_CCAP   = 4'd2;
    localparam logic [3:0] S_WALK   = 4'd3;
    localparam logic [3:0] S_WEND   = 4'd4;
    localparam logic [3:0] S_ESTART = 4'd5;
    localparam logic [3:0] S_ERD    = 4'd6;
    localparam logic [3:0] S_ECAP   = 4'd7;
    localparam logic [3:0] S_EMUL   = 4'd8;
    localparam logic [3:0] S_EADD   = 4'd9;
    localparam logic [3:0] S_EDIV   = 4'd10;
    localparam logic [3:0] S_EOUT   = 4'd11;
    localparam logic [3:0] S_NONE   = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                cmd.load = 1'b1;
                if (sts.in_last)
                begin
                    state_next = S_CREAD;
                end
            end
            S_CREAD:
            begin
                cmd.centre_rd = 1'b1;
                state_next    = S_CCAP;
            end
            S_CCAP:
            begin
                cmd.centre_cap = 1'b1;
                state_next     = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_end)
                begin
                    state_next = S_WEND;
                end
            end
            S_WEND:
            begin
                state_next = S_ESTART;
            end
            S_ESTART:
            begin
                cmd.emit_init = 1'b1;
                state_next    = sts.no_picks ? S_NONE : S_ERD;
            end
            S_ERD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_ECAP;
            end
            S_ECAP:
            begin
                cmd.emit_cap = 1'b1;
                state_next   = S_EMUL;
            end
            S_EMUL:
            begin
                cmd.emit_mul = 1'b1;
                state_next   = S_EADD;
            end
            S_EADD:
            begin
                cmd.emit_add = 1'b1;
                state_next   = S_EDIV;
            end
            S_EDIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_EOUT;
                end
            end
            S_EOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.emit_last)
                    begin
                        cmd.clear_row = 1'b1;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_ERD;
                    end
                end
            end
            S_NONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_none  = 1'b1;
                    cmd.clear_row = 1'b1;
                    state_next    = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end
endmodule

FILE: rtl/core/rpf_dp.sv
// Datapath: row store, min/max tracking, derivative walk, pick buffer and level divider.
module rpf_dp #(
    parameter int MAX_LEN     = 256,
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_PEAKS   = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    rpf_sample_if.sink         samples,
    rpf_peak_if.source         peaks,
    input  rpf_pkg::rpf_cmd_t  cmd,
    output rpf_pkg::rpf_sts_t  sts
);
    import rpf_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int IDX_W  = $clog2(MAX_LEN);
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int CNT_W  = $clog2(MAX_PEAKS + 1);
    localparam int PK_AW  = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
    localparam int PICK_W = IDX_W + SB;
    localparam int RW     = SB + 2;
    localparam int NW     = SB + 18;
    localparam int DC_W   = $clog2(LEVEL_W);

    // row load
    logic [SB+SAMPLE_W-1:0] s_ext;
    logic [SB-1:0]          s_in;
    logic                   in_acc;
    logic                   store_ok;
    logic [LEN_W-1:0]       len_reg;
    logic [SB-1:0]          min_reg;
    logic [SB-1:0]          max_reg;
    logic [SB-1:0]          centre_reg;
    logic [SB-1:0]          span_reg;

    // row memory
    logic [IDX_W-1:0]       row_raddr;
    logic [SB-1:0]          row_rdata;

    // walk
    logic [LEN_W-1:0]       walk_ptr_reg;
    logic                   tag_v_reg;
    logic [LEN_W-1:0]       tag_j_reg;
    logic [SB-1:0]          w0_reg;
    logic [SB-1:0]          w1_reg;
    logic [SB-1:0]          w2_reg;
    logic signed [SB:0]     d0;
    logic signed [SB:0]     d1;
    logic                   crossing;
    logic                   pick_right;
    logic [IDX_W-1:0]       cand_i;
    logic [IDX_W-1:0]       cand_idx;
    logic [SB-1:0]          cand_val;
    logic                   eval_hit;
    logic                   pick_we;

    // pick buffer
    logic [CNT_W-1:0]       cnt_reg;
    logic                   over_reg;
    logic [CNT_W-1:0]       k_reg;
    logic [PICK_W-1:0]      pick_wdata;
    logic [PICK_W-1:0]      pick_rdata;

    // level arithmetic
    logic [IDX_W-1:0]       pidx_reg;
    logic [SB-1:0]          x_reg;
    logic [SB+16:0]         num2_reg;
    logic [NW-1:0]          nsum;
    logic [RW-1:0]          rem_reg;
    logic [LEVEL_W-1:0]     dlo_reg;
    logic [LEVEL_W-1:0]     q_reg;
    logic [DC_W-1:0]        div_cnt_reg;
    logic [RW-1:0]          rem_sh;
    logic [RW-1:0]          divisor;
    logic                   rem_ge;

    // output register
    logic                   out_valid_reg;
    logic [INDEX_W-1:0]     out_index_reg;
    logic [LEVEL_W-1:0]     out_level_reg;
    logic                   out_none_reg;
    logic                   out_over_reg;
    logic                   out_last_reg;
    logic                   emit_last;

    assign s_ext    = {{SB{1'b0}}, samples.sample};
    assign s_in     = s_ext[SB-1:0];
    assign samples.ready = cmd.load;
    assign in_acc   = samples.valid && cmd.load;
    assign store_ok = len_reg < LEN_W'(MAX_LEN);

    assign row_raddr = cmd.centre_rd ? IDX_W'(len_reg >> 1) : walk_ptr_reg[IDX_W-1:0];

    rpf_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_LEN)
    ) u_row_ram (
        .clk   (clk),
        .we    (in_acc && store_ok),
        .waddr (len_reg[IDX_W-1:0]),
        .wdata (s_in),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    // window: w0 = s[i-1], w1 = s[i], w2 = s[i+1], row_rdata = s[i+2] with i = tag - 2
    assign d0 = (tag_j_reg == LEN_W'(2)) ? '0 :
                $signed({1'b0, w2_reg}) - $signed({1'b0, w0_reg});
    assign d1 = (tag_j_reg == len_reg) ? '0 :
                $signed({1'b0, row_rdata}) - $signed({1'b0, w1_reg});
    assign crossing   = (d0 >= 0) && (d1 <= 0) && (d0 > d1);
    assign pick_right = !(w1_reg > w2_reg);
    assign cand_i     = IDX_W'(tag_j_reg - LEN_W'(2));
    assign cand_idx   = pick_right ? cand_i + IDX_W'(1) : cand_i;
    assign cand_val   = pick_right ? w2_reg : w1_reg;
    assign eval_hit   = tag_v_reg && (tag_j_reg >= LEN_W'(2)) && crossing
                        && (cand_val >= centre_reg);
    assign pick_we    = eval_hit && (cnt_reg < CNT_W'(MAX_PEAKS));
    assign pick_wdata = {cand_idx, cand_val};

    rpf_ram #(
        .WIDTH (PICK_W),
        .DEPTH (MAX_PEAKS)
    ) u_pick_ram (
        .clk   (clk),
        .we    (pick_we),
        .waddr (cnt_reg[PK_AW-1:0]),
        .wdata (pick_wdata),
        .raddr (k_reg[PK_AW-1:0]),
        .rdata (pick_rdata)
    );

    assign nsum    = NW'(num2_reg) + NW'(span_reg);
    assign divisor = RW'({span_reg, 1'b0});
    assign rem_sh  = {rem_reg[RW-2:0], dlo_reg[LEVEL_W-1]};
    assign rem_ge  = rem_sh >= divisor;
    assign emit_last = (k_reg + CNT_W'(1)) == cnt_reg;

    assign sts.in_last   = in_acc && samples.last_sample;
    assign sts.walk_end  = walk_ptr_reg == len_reg;
    assign sts.no_picks  = cnt_reg == '0;
    assign sts.div_done  = div_cnt_reg == '0;
    assign sts.emit_last = emit_last;
    assign sts.out_free  = !out_valid_reg || peaks.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            min_reg       <= '1;
            max_reg       <= '0;
            walk_ptr_reg  <= '0;
            tag_v_reg     <= 1'b0;
            cnt_reg       <= '0;
            over_reg      <= 1'b0;
            k_reg         <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_row)
            begin
                len_reg <= '0;
                min_reg <= '1;
                max_reg <= '0;
            end
            else if (in_acc && store_ok)
            begin
                len_reg <= len_reg + LEN_W'(1);
                if (s_in < min_reg)
                begin
                    min_reg <= s_in;
                end
                if (s_in > max_reg)
                begin
                    max_reg <= s_in;
                end
            end

            if (cmd.centre_rd)
            begin
                walk_ptr_reg <= '0;
                cnt_reg      <= '0;
                over_reg     <= 1'b0;
            end
            else
            begin
                if (cmd.walk && !sts.walk_end)
                begin
                    walk_ptr_reg <= walk_ptr_reg + LEN_W'(1);
                end
                if (pick_we)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                else if (eval_hit)
                begin
                    over_reg <= 1'b1;
                end
            end
            tag_v_reg <= cmd.walk;

            if (cmd.emit_init)
            begin
                k_reg <= '0;
            end
            else if (cmd.out_load)
            begin
                k_reg <= k_reg + CNT_W'(1);
            end

            if (cmd.emit_add)
            begin
                div_cnt_reg <= DC_W'(LEVEL_W - 1);
            end
            else if (cmd.div_step && !sts.div_done)
            begin
                div_cnt_reg <= div_cnt_reg - DC_W'(1);
            end

            if (cmd.out_load || cmd.out_none)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (peaks.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.centre_cap)
        begin
            centre_reg <= row_rdata;
            span_reg   <= max_reg - min_reg;
        end
        if (cmd.walk)
        begin
            tag_j_reg <= walk_ptr_reg;
        end
        if (tag_v_reg)
        begin
            w0_reg <= w1_reg;
            w1_reg <= w2_reg;
            w2_reg <= row_rdata;
        end
        if (cmd.emit_cap)
        begin
            pidx_reg <= pick_rdata[PICK_W-1:SB];
            x_reg    <= pick_rdata[SB-1:0] - min_reg;
        end
        if (cmd.emit_mul)
        begin
            num2_reg <= {x_reg, 17'b0} - (SB+17)'({x_reg, 1'b0});
        end
        if (cmd.emit_add)
        begin
            rem_reg <= nsum[NW-1:LEVEL_W];
            dlo_reg <= nsum[LEVEL_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_sh - divisor : rem_sh;
            dlo_reg <= {dlo_reg[LEVEL_W-2:0], 1'b0};
            q_reg   <= {q_reg[LEVEL_W-2:0], rem_ge};
        end
        if (cmd.out_load)
        begin
            out_index_reg <= INDEX_W'(pidx_reg);
            out_level_reg <= (span_reg == '0) ? '0 : q_reg;
            out_none_reg  <= 1'b0;
            out_over_reg  <= emit_last && over_reg;
            out_last_reg  <= emit_last;
        end
        else if (cmd.out_none)
        begin
            out_index_reg <= '0;
            out_level_reg <= '0;
            out_none_reg  <= 1'b1;
            out_over_reg  <= 1'b0;
            out_last_reg  <= 1'b1;
        end
    end

    assign peaks.valid       = out_valid_reg;
    assign peaks.peak_index  = out_index_reg;
    assign peaks.peak_level  = out_level_reg;
    assign peaks.no_peak     = out_none_reg;
    assign peaks.overflow    = out_over_reg;
    assign peaks.last_result = out_last_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_PEAKS))
        else $error("pick count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_LEN))
        else $error("row length beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != '0) |-> (min_reg <= max_reg))
        else $error("row minimum above row maximum");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load || cmd.out_none) |-> (!out_valid_reg || peaks.ready))
        else $error("output register overwritten while a beat waits");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_rd) |-> (k_reg < cnt_reg))
        else $error("pick read beyond stored picks");
`endif
endmodule

FILE: verif/tb.sv
// Testbench for row_peak_finder: streams sample rows, predicts the peak beats and checks them.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpf_pkg::*;

    localparam int ROW_DEPTH   = MAX_LEN_DEF;
    localparam int PEAK_CAP    = MAX_PEAKS_DEF;
    localparam int HOLD_CYCLES = 1200;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 60;
    localparam int CALM_TAIL   = 20;

    typedef struct {
        logic [INDEX_W-1:0] peak_index;
        logic [LEVEL_W-1:0] peak_level;
        logic               no_peak;
        logic               overflow;
        logic               last_result;
    } peak_t;

    class peak_ledger;
        peak_t               expected_q[$];
        logic [SAMPLE_W-1:0] row_mem [ROW_DEPTH];
        int unsigned         row_len;
        logic [SAMPLE_W-1:0] row_lo;
        logic [SAMPLE_W-1:0] row_hi;
        int                  errors;

        function new();
            errors = 0;
            clear_row();
        endfunction

        function void clear_row();
            row_len = 0;
            row_lo  = '1;
            row_hi  = '0;
        endfunction

        function void expect_beat(peak_t pk);
            expected_q.insert(expected_q.size(), pk);
        endfunction

        function int slope(int i, int n);
            int a;
            int b;
            if (i == 0 || i + 1 >= n)
                return 0;
            a = row_mem[i+1];
            b = row_mem[i-1];
            return a - b;
        endfunction

        function logic [LEVEL_W-1:0] level_of(logic [SAMPLE_W-1:0] v);
            longint unsigned span;
            longint unsigned num;
            if (row_hi <= row_lo || v < row_lo)
                return '0;
            span = row_hi - row_lo;
            num  = v - row_lo;
            num  = num * 65535;
            return LEVEL_W'((num * 2 + span) / (span * 2));
        endfunction

        function void find_peaks();
            int                  n;
            int                  d0;
            int                  d1;
            int                  p;
            int                  picks[PEAK_CAP];
            int                  count;
            bit                  over;
            logic [SAMPLE_W-1:0] centre;
            peak_t               pk;
            n      = row_len;
            centre = row_mem[n/2];
            over   = 0;
            count  = 0;
            for (int i = 0; i + 1 < n; i++)
            begin
                d0 = slope(i, n);
                d1 = slope(i + 1, n);
                if (!(d0 >= 0 && d1 <= 0 && d0 > d1))
                    continue;
                p = (row_mem[i] > row_mem[i+1]) ? i : i + 1;
                if (row_mem[p] < centre)
                    continue;
                if (count < PEAK_CAP)
                begin
                    picks[count] = p;
                    count++;
                end
                else
                    over = 1;
            end
            if (count == 0)
            begin
                pk.peak_index  = '0;
                pk.peak_level  = '0;
                pk.no_peak     = 1'b1;
                pk.overflow    = 1'b0;
                pk.last_result = 1'b1;
                expect_beat(pk);
            end
            else
            begin
                for (int k = 0; k < count; k++)
                begin
                    pk.peak_index  = INDEX_W'(picks[k]);
                    pk.peak_level  = level_of(row_mem[picks[k]]);
                    pk.no_peak     = 1'b0;
                    pk.last_result = (k == count - 1);
                    pk.overflow    = pk.last_result && over;
                    expect_beat(pk);
                end
            end
            clear_row();
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s, logic last);
            if (row_len < ROW_DEPTH)
            begin
                row_mem[row_len] = s;
                row_len++;
                if (s < row_lo)
                    row_lo = s;
                if (s > row_hi)
                    row_hi = s;
            end
            if (last)
                find_peaks();
        endfunction

        task report(string what);
            $display("peak mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_peak(peak_t got);
            peak_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected beat index %0d level %0d",
                                 got.peak_index, got.peak_level));
                return;
            end
            want = expected_q.pop_front();
            if (got.peak_index !== want.peak_index)
                report($sformatf("peak_index got %0d want %0d",
                                 got.peak_index, want.peak_index));
            if (got.peak_level !== want.peak_level)
                report($sformatf("peak_level got %0d want %0d (index %0d)",
                                 got.peak_level, want.peak_level, want.peak_index));
            if (got.no_peak !== want.no_peak)
                report($sformatf("no_peak got %b want %b", got.no_peak, want.no_peak));
            if (got.overflow !== want.overflow)
                report($sformatf("overflow got %b want %b", got.overflow, want.overflow));
            if (got.last_result !== want.last_result)
                report($sformatf("last_result got %b want %b",
                                 got.last_result, want.last_result));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    bit   calm;
    bit   hold_req;
    int   stall_left;

    logic [SAMPLE_W-1:0] row_q[$];
    peak_ledger          ledger;

    rpf_sample_if samples_ch ();
    rpf_peak_if   peaks_ch ();

    row_peak_finder i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .peaks   (peaks_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && samples_ch.valid && samples_ch.ready)
            ledger.note_sample(samples_ch.sample, samples_ch.last_sample);
    end

    always @(posedge clk)
    begin
        peak_t got;
        if (rst_n && peaks_ch.valid && peaks_ch.ready)
        begin
            got.peak_index  = peaks_ch.peak_index;
            got.peak_level  = peaks_ch.peak_level;
            got.no_peak     = peaks_ch.no_peak;
            got.overflow    = peaks_ch.overflow;
            got.last_result = peaks_ch.last_result;
            ledger.check_peak(got);
        end
    end

    // Receiver: random stall bursts, one long hold on request, none once calm.
    initial
    begin
        peaks_ch.ready = 1'b0;
        stall_left     = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                peaks_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (hold_req)
            begin
                hold_req = 0;
                stall_left = HOLD_CYCLES - 1;
                peaks_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                peaks_ch.ready <= 1'b0;
            end
            else
                peaks_ch.ready <= 1'b1;
        end
    end

    function automatic void add_sample(input logic [SAMPLE_W-1:0] v);
        row_q.insert(row_q.size(), v);
    endfunction

    task automatic send_beat(input logic [SAMPLE_W-1:0] s, input logic last);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            repeat (gap)
            begin
                @(negedge clk);
                samples_ch.valid <= 1'b0;
            end
        end
        @(negedge clk);
        samples_ch.valid       <= 1'b1;
        samples_ch.sample      <= s;
        samples_ch.last_sample <= last;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_row();
        foreach (row_q[k])
            send_beat(row_q[k], k == row_q.size() - 1);
        row_q.delete();
    endtask

    task automatic make_random_row(input int len);
        int                  style;
        logic [SAMPLE_W-1:0] base;
        style = $urandom_range(0, 3);
        base  = SAMPLE_W'($urandom_range(0, 65531));
        for (int k = 0; k < len; k++)
        begin
            case (style)
                0: add_sample(SAMPLE_W'($urandom_range(0, 65535)));
                1: add_sample(base + SAMPLE_W'($urandom_range(0, 3)));
                2: add_sample((k % 4 == 1) ? SAMPLE_W'($urandom_range(30000, 65535))
                                           : SAMPLE_W'($urandom_range(0, 29999)));
                default: add_sample(base);
            endcase
        end
    endtask

    initial
    begin
        int sent;
        int len;
        int pick;
        rst_n                  = 1'b0;
        calm                   = 0;
        hold_req               = 0;
        samples_ch.valid       = 1'b0;
        samples_ch.sample      = '0;
        samples_ch.last_sample = 1'b0;
        ledger = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single sample, two samples, flat row: no peak
        row_q = '{16'hFFFF};
        send_row();
        row_q = '{16'h0000, 16'hFFFF};
        send_row();
        row_q = '{16'd1234, 16'd1234, 16'd1234, 16'd1234};
        send_row();
        // full-scale peak, tie to the right, same index twice, plateau
        row_q = '{16'd0, 16'd100, 16'hFFFF, 16'd0};
        send_row();
        row_q = '{16'd0, 16'd7, 16'd7, 16'd0};
        send_row();
        row_q = '{16'd0, 16'd1, 16'hFFFF, 16'd1, 16'd0};
        send_row();
        row_q = '{16'd0, 16'd5, 16'd5, 16'd5, 16'd0};
        send_row();
        // the centre sample is zero here, so the low peak at 300 is kept beside the high one
        row_q = '{16'd0, 16'd300, 16'd0, 16'd0, 16'd900, 16'd901, 16'd0};
        send_row();

        // peaks past the cap; dropped extremes past the row end leave min/max alone
        hold_req = 1;
        for (int k = 0; k < ROW_DEPTH; k++)
        begin
            case (k % 3)
                0: add_sample(16'd100);
                1: add_sample(SAMPLE_W'($urandom_range(101, 60000)));
                default: add_sample(16'd60001);
            endcase
        end
        for (int k = 0; k < 4; k++)
            add_sample((k % 2 == 0) ? 16'h0000 : 16'hFFFF);
        send_row();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                len = $urandom_range(1, 2);
            else if (pick == 9)
                len = $urandom_range(25, 40);
            else
                len = $urandom_range(3, 16);
            make_random_row(len);
            sent += len;
            send_row();
            if (sent >= RANDOM_ITEMS - CALM_TAIL)
                calm = 1;
        end
        @(negedge clk);
        samples_ch.valid <= 1'b0;

        while (ledger.expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (ledger.errors == 0 && ledger.expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
